/* rtl/hcbd_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hcbd_pkg: shared types and constants for the chunked body decoder
// Phase encoding, byte class codes, match strings and byte helpers.
// ----------------------------------------------------------------------------
package hcbd_pkg;

   typedef enum logic [2:0] {
      PH_HEADER   = 3'd0,
      PH_RAW      = 3'd1,
      PH_SIZE     = 3'd2,
      PH_SIZELINE = 3'd3,
      PH_DATA     = 3'd4,
      PH_TRAILER  = 3'd5,
      PH_STOP     = 3'd6
   } phase_type;

   localparam int BYTE_W  = 8;
   localparam int CLASS_W = 3;

   localparam logic [CLASS_W-1:0] CLS_HEADER    = 3'd0;
   localparam logic [CLASS_W-1:0] CLS_RAW       = 3'd1;
   localparam logic [CLASS_W-1:0] CLS_DATA      = 3'd2;
   localparam logic [CLASS_W-1:0] CLS_FRAMING   = 3'd3;
   localparam logic [CLASS_W-1:0] CLS_AFTER_END = 3'd4;
   localparam logic [CLASS_W-1:0] CLS_OVERSIZE  = 3'd5;

   localparam logic [31:0] MAX_CHUNK_LEN_RESET = 32'd1048576;

   localparam logic [7:0] CHAR_CR = 8'h0D;
   localparam logic [7:0] CHAR_LF = 8'h0A;

   localparam logic [4:0] NAME_LAST   = 5'd16;  // index of final char of name
   localparam logic [2:0] WORD_LAST   = 3'd6;
   localparam logic [2:0] WORD_CLOSED = 3'd7;

   // "transfer-encoding", lower case
   function automatic logic [7:0] enc_char(input logic [4:0] idx);
      logic [7:0] c;
      unique case (idx)
         5'd0:    c = "t";
         5'd1:    c = "r";
         5'd2:    c = "a";
         5'd3:    c = "n";
         5'd4:    c = "s";
         5'd5:    c = "f";
         5'd6:    c = "e";
         5'd7:    c = "r";
         5'd8:    c = "-";
         5'd9:    c = "e";
         5'd10:   c = "n";
         5'd11:   c = "c";
         5'd12:   c = "o";
         5'd13:   c = "d";
         5'd14:   c = "i";
         5'd15:   c = "n";
         5'd16:   c = "g";
         default: c = 8'h00;
      endcase
      return c;
   endfunction

   // "chunked"
   function automatic logic [7:0] chk_char(input logic [2:0] idx);
      logic [7:0] c;
      unique case (idx)
         3'd0:    c = "c";
         3'd1:    c = "h";
         3'd2:    c = "u";
         3'd3:    c = "n";
         3'd4:    c = "k";
         3'd5:    c = "e";
         3'd6:    c = "d";
         default: c = 8'h00;
      endcase
      return c;
   endfunction

   function automatic logic [7:0] fold(input logic [7:0] b);
      return (b >= "A" && b <= "Z") ? (b + 8'd32) : b;
   endfunction

   // bit 4 = valid hex digit, [3:0] = value
   function automatic logic [4:0] hex_digit(input logic [7:0] b);
      logic [4:0] r;
      if (b >= "0" && b <= "9") begin
         r = {1'b1, 4'(b - "0")};
      end else if (b >= "a" && b <= "f") begin
         r = {1'b1, 4'(b - "a" + 8'd10)};
      end else if (b >= "A" && b <= "F") begin
         r = {1'b1, 4'(b - "A" + 8'd10)};
      end else begin
         r = 5'd0;
      end
      return r;
   endfunction

endpackage

`default_nettype wire

/* rtl/hcbd_req_if.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hcbd_req_if: request channel of the chunked body decoder
// One response byte per transaction, with an end-of-response flag.
// ----------------------------------------------------------------------------
interface hcbd_req_if;
   logic                          valid;
   logic                          ready;
   logic [hcbd_pkg::BYTE_W-1:0]   in_byte;
   logic                          in_last;

   modport source (output valid, output in_byte, output in_last, input ready);
   modport sink   (input valid, input in_byte, input in_last, output ready);
endinterface
`default_nettype wire

/* rtl/hcbd_rsp_if.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hcbd_rsp_if: response channel of the chunked body decoder
// Echoed byte with keep flag, end flag and byte class.
// ----------------------------------------------------------------------------
interface hcbd_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [hcbd_pkg::BYTE_W-1:0]   out_byte;
   logic                          keep;
   logic                          out_last;
   logic [hcbd_pkg::CLASS_W-1:0]  byte_class;

   modport source (output valid, output out_byte, output keep, output out_last,
                   output byte_class, input ready);
   modport sink   (input valid, input out_byte, input keep, input out_last,
                   input byte_class, output ready);
endinterface
`default_nettype wire

/* rtl/http_chunked_body_decoder.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// http_chunked_body_decoder: streaming HTTP chunked transfer decoder
// Classifies each response byte (header, raw body, chunk data, framing,
// dropped, oversize) and marks whether it belongs to the decoded response.
// ----------------------------------------------------------------------------
// Response valid rises in the cycle after the request transaction.
// Throughput: 1 byte per cycle while rsp_ch is not stalled; decode state updates in a
//   single pass at the accepting edge and the result lands in one output register.
// Reset: synchronous, active high; decoder returns to header phase and
//   max_chunk_len returns to 1048576. State also clears after in_last.
module http_chunked_body_decoder (
   input  wire logic           clock,
   input  wire logic           reset,
   hcbd_req_if.sink            req_ch,
   hcbd_rsp_if.source          rsp_ch,
   input  wire logic           csr_we,
   input  wire logic [31:0]    csr_wdata
);

   logic [31:0]          max_len_ff;

   hcbd_pkg::phase_type  phase_ff, phase_in;
   logic [1:0]           eoh_ff, eoh_in;
   logic [4:0]           enc_ff, enc_in;
   logic [2:0]           chk_ff, chk_in;
   logic                 seen_ff, seen_in;
   logic                 chunked_ff, chunked_in;
   logic [32:0]          acc_ff, acc_in;
   logic [31:0]          left_ff, left_in;
   logic                 pcr_ff, pcr_in;

   logic                             rsp_valid_ff;
   logic [hcbd_pkg::BYTE_W-1:0]      rsp_byte_ff;
   logic                             rsp_keep_ff, rsp_keep_in;
   logic                             rsp_last_ff;
   logic [hcbd_pkg::CLASS_W-1:0]     rsp_class_ff, rsp_class_in;

   logic       req_fire;
   logic [7:0] b;
   logic [7:0] lb;
   logic [4:0] hex;

   assign req_ch.ready = !rsp_valid_ff || rsp_ch.ready;
   assign req_fire     = req_ch.valid && req_ch.ready;
   assign b            = req_ch.in_byte;
   assign lb           = hcbd_pkg::fold(b);
   assign hex          = hcbd_pkg::hex_digit(b);

   always_comb begin
      phase_in     = phase_ff;
      eoh_in       = eoh_ff;
      enc_in       = enc_ff;
      chk_in       = chk_ff;
      seen_in      = seen_ff;
      chunked_in   = chunked_ff;
      acc_in       = acc_ff;
      left_in      = left_ff;
      pcr_in       = pcr_ff;
      rsp_keep_in  = 1'b0;
      rsp_class_in = hcbd_pkg::CLS_AFTER_END;

      unique case (phase_ff)
         hcbd_pkg::PH_HEADER: begin
            rsp_keep_in  = 1'b1;
            rsp_class_in = hcbd_pkg::CLS_HEADER;
            if (!seen_ff) begin
               if (lb == hcbd_pkg::enc_char(enc_ff)) begin
                  if (enc_ff == hcbd_pkg::NAME_LAST) begin
                     seen_in = 1'b1;
                     enc_in  = 5'd0;
                  end else begin
                     enc_in = enc_ff + 5'd1;
                  end
               end else begin
                  enc_in = (lb == hcbd_pkg::enc_char(5'd0)) ? 5'd1 : 5'd0;
               end
            end else if (chk_ff != hcbd_pkg::WORD_CLOSED) begin
               if (b == hcbd_pkg::CHAR_LF && eoh_ff[0]) begin
                  chk_in = hcbd_pkg::WORD_CLOSED;   // encoding line ended
               end else if (lb == hcbd_pkg::chk_char(chk_ff)) begin
                  if (chk_ff == hcbd_pkg::WORD_LAST) begin
                     chunked_in = 1'b1;
                     chk_in     = hcbd_pkg::WORD_CLOSED;
                  end else begin
                     chk_in = chk_ff + 3'd1;
                  end
               end else begin
                  chk_in = (lb == hcbd_pkg::chk_char(3'd0)) ? 3'd1 : 3'd0;
               end
            end
            // CR LF CR LF tracker
            if (b == hcbd_pkg::CHAR_CR) begin
               eoh_in = (eoh_ff == 2'd2) ? 2'd3 : 2'd1;
            end else if (b == hcbd_pkg::CHAR_LF) begin
               if (eoh_ff == 2'd1) begin
                  eoh_in = 2'd2;
               end else if (eoh_ff == 2'd3) begin
                  eoh_in = 2'd0;
                  if (chunked_in) begin
                     phase_in = hcbd_pkg::PH_SIZE;
                     acc_in   = 33'd0;
                  end else begin
                     phase_in = hcbd_pkg::PH_RAW;
                  end
               end else begin
                  eoh_in = 2'd0;
               end
            end else begin
               eoh_in = 2'd0;
            end
         end
         hcbd_pkg::PH_RAW: begin
            rsp_keep_in  = 1'b1;
            rsp_class_in = hcbd_pkg::CLS_RAW;
         end
         hcbd_pkg::PH_SIZE: begin
            rsp_class_in = hcbd_pkg::CLS_FRAMING;
            if (hex[4]) begin
               // bit 32 is sticky once a digit shifts out of the low word
               acc_in = {acc_ff[32] | (|acc_ff[31:28]), acc_ff[27:0], hex[3:0]};
            end else if (acc_ff == 33'd0) begin
               phase_in = hcbd_pkg::PH_STOP;
            end else if (acc_ff[32] || (acc_ff[31:0] > max_len_ff)) begin
               rsp_class_in = hcbd_pkg::CLS_OVERSIZE;
               phase_in     = hcbd_pkg::PH_STOP;
            end else begin
               left_in  = acc_ff[31:0];
               pcr_in   = (b == hcbd_pkg::CHAR_CR);
               phase_in = hcbd_pkg::PH_SIZELINE;
            end
         end
         hcbd_pkg::PH_SIZELINE: begin
            rsp_class_in = hcbd_pkg::CLS_FRAMING;
            if (pcr_ff && b == hcbd_pkg::CHAR_LF) begin
               phase_in = hcbd_pkg::PH_DATA;
               pcr_in   = 1'b0;
            end else begin
               pcr_in = (b == hcbd_pkg::CHAR_CR);
            end
         end
         hcbd_pkg::PH_DATA: begin
            rsp_keep_in  = 1'b1;
            rsp_class_in = hcbd_pkg::CLS_DATA;
            left_in      = (left_ff != 32'd0) ? (left_ff - 32'd1) : left_ff;
            if (left_in == 32'd0) begin
               phase_in = hcbd_pkg::PH_TRAILER;
               pcr_in   = 1'b0;
            end
         end
         hcbd_pkg::PH_TRAILER: begin
            rsp_class_in = hcbd_pkg::CLS_FRAMING;
            if (pcr_ff) begin
               pcr_in   = 1'b0;
               acc_in   = 33'd0;
               phase_in = hcbd_pkg::PH_SIZE;
            end else begin
               pcr_in = 1'b1;
            end
         end
         default: begin
            phase_in = hcbd_pkg::PH_STOP;
         end
      endcase

      if (req_ch.in_last) begin
         phase_in   = hcbd_pkg::PH_HEADER;
         eoh_in     = 2'd0;
         enc_in     = 5'd0;
         chk_in     = 3'd0;
         seen_in    = 1'b0;
         chunked_in = 1'b0;
         acc_in     = 33'd0;
         left_in    = 32'd0;
         pcr_in     = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         max_len_ff <= hcbd_pkg::MAX_CHUNK_LEN_RESET;
         phase_ff   <= hcbd_pkg::PH_HEADER;
         eoh_ff     <= 2'd0;
         enc_ff     <= 5'd0;
         chk_ff     <= 3'd0;
         seen_ff    <= 1'b0;
         chunked_ff <= 1'b0;
         acc_ff     <= 33'd0;
         left_ff    <= 32'd0;
         pcr_ff     <= 1'b0;
      end else begin
         if (csr_we) begin
            max_len_ff <= csr_wdata;
         end
         if (req_fire) begin
            phase_ff   <= phase_in;
            eoh_ff     <= eoh_in;
            enc_ff     <= enc_in;
            chk_ff     <= chk_in;
            seen_ff    <= seen_in;
            chunked_ff <= chunked_in;
            acc_ff     <= acc_in;
            left_ff    <= left_in;
            pcr_ff     <= pcr_in;
         end
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (req_fire) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ch.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         rsp_byte_ff  <= b;
         rsp_keep_ff  <= rsp_keep_in;
         rsp_last_ff  <= req_ch.in_last;
         rsp_class_ff <= rsp_class_in;
      end
   end

   assign rsp_ch.valid      = rsp_valid_ff;
   assign rsp_ch.out_byte   = rsp_byte_ff;
   assign rsp_ch.keep       = rsp_keep_ff;
   assign rsp_ch.out_last   = rsp_last_ff;
   assign rsp_ch.byte_class = rsp_class_ff;

`ifndef SYNTHESIS
   a_fire_gives_rsp: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> rsp_valid_ff)
      else $error("accepted transaction did not produce a response");

   a_keep_matches_class: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_keep_ff == (rsp_class_ff == hcbd_pkg::CLS_HEADER ||
                                        rsp_class_ff == hcbd_pkg::CLS_RAW ||
                                        rsp_class_ff == hcbd_pkg::CLS_DATA)))
      else $error("keep flag disagrees with byte class");

   a_last_clears: assert property (@(posedge clock) disable iff (reset)
      (req_fire && req_ch.in_last) |=> (phase_ff == hcbd_pkg::PH_HEADER && !seen_ff))
      else $error("decoder state not cleared after end of response");

   a_data_count: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == hcbd_pkg::PH_DATA) |-> (left_ff != 32'd0))
      else $error("data phase with no bytes left");

   a_chunked_needs_name: assert property (@(posedge clock) disable iff (reset)
      chunked_ff |-> seen_ff)
      else $error("chunked mode without transfer-encoding seen");
`endif

endmodule
`default_nettype wire
